// ----- sv/mtbb_pkg.sv -----
// shared types, constants and tables for the tick to bar and beat converter
`timescale 1ns / 1ps

package mtbb_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W = 32;
  localparam int LEN_W  = 26;
  localparam int DIV_W  = 42;
  localparam int STEP_W = 6;

  localparam logic [LEN_W-1:0]  DEFAULT_BAR_TICKS = 26'd960;
  localparam logic [7:0]        DEFAULT_BEATS     = 8'd4;
  localparam logic [14:0]       TPQ_RESET         = 15'd480;
  localparam logic [STEP_W-1:0] STEPS_BARS        = 6'd32;
  localparam logic [STEP_W-1:0] STEPS_BEAT        = 6'd42;

  typedef logic [5:0] quot_tab_t [64];

  // 32 / denominator, zero where the denominator is not usable
  localparam quot_tab_t DEN_QUOT = '{
    6'd0, 6'd32, 6'd16, 6'd10, 6'd8, 6'd6, 6'd5, 6'd4,
    6'd4, 6'd3, 6'd3, 6'd2, 6'd2, 6'd2, 6'd2, 6'd2,
    6'd2, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1,
    6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1,
    6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
  };

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_RESET   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_APSTART,
    S_APWAIT,
    S_QSTART,
    S_QWAIT,
    S_QMUL,
    S_QSUM,
    S_BWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick;
    logic [7:0]        num;
    logic [5:0]        den;
  } sig_entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [LEN_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [LEN_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- sv/midi_tick_to_bar_beat.sv -----
// Converts MIDI tick times to a 1-based bar number and a Q8 beat position,
// applying queued time signatures in order. One item is processed at a
// time; s_tready is high whenever the sequencer is idle, even while a result
// waits on the master side. Enqueue, timing reset and the unused command do
// not use the divider. A query uses the shared serial divider once for each
// queued signature it applies and twice more for the bar count and the beat;
// the divider produces one quotient bit per cycle (32 bits for the bar count, 42
// for the beat). The signature queue sits in a memory with a registered read,
// so its head entry follows the head pointer in the next cycle.
`timescale 1ns / 1ps

module midi_tick_to_bar_beat import mtbb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // event_time[31:0], numerator[39:32], denominator[45:40]
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // bar_number[31:0], beat_q8[49:32]
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  state_t state;
  state_t state_next;

  cmd_t              cmd;
  logic [TIME_W-1:0] tick;
  logic [7:0]        in_num;
  logic [5:0]        in_den;
  sig_entry_t        e;
  logic [19:0]       prod1;
  logic [LEN_W-1:0]  new_len;
  logic [TIME_W-1:0] base_tick;
  logic [TIME_W-1:0] base_bar;
  logic [LEN_W-1:0]  bar_len;
  logic [7:0]        beats;
  logic [14:0]       tpq;
  logic              neg;
  logic [TIME_W-1:0] bars32;
  logic [LEN_W-1:0]  rmag;
  logic [33:0]       prod_p;
  logic              xneg;
  status_t           res_status;
  logic [TIME_W-1:0] res_bar;
  logic [17:0]       res_beat;
  status_t           out_status;
  logic [TIME_W-1:0] out_bar;
  logic [17:0]       out_beat;

  sig_entry_t        head_entry;
  sig_entry_t        wr_entry;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              zero_len;
  logic              full;
  logic              can_apply;
  logic [TIME_W-1:0] sel_time;
  logic              d_neg;
  logic [TIME_W-1:0] d_mag;
  logic [33:0]       len_ext;
  logic [33:0]       xmag;
  logic              xneg_c;
  logic [TIME_W-1:0] q_signed;
  logic [TIME_W-1:0] rem_ext;
  logic              snap;
  logic [TIME_W-1:0] last_bar;
  logic              out_load;

  mtbb_sig_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .count      (count)
  );

  mtbb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign wr_entry.tick = tick;
  assign wr_entry.num  = in_num;
  assign wr_entry.den  = in_den;

  assign zero_len  = (in_num == 8'd0) || (DEN_QUOT[in_den] == 6'd0) || (tpq[14:3] == 12'd0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign can_apply = (count != '0) && (head_entry.tick <= tick);

  // signed distance from the base tick, as sign and magnitude
  assign sel_time = (state == S_APSTART) ? e.tick : tick;
  assign d_neg    = sel_time < base_tick;
  assign d_mag    = d_neg ? (base_tick - sel_time) : (sel_time - base_tick);

  always_comb begin
    len_ext = {8'd0, bar_len};
    if (!neg) begin
      xmag   = len_ext + prod_p;
      xneg_c = 1'b0;
    end else if (prod_p > len_ext) begin
      xmag   = prod_p - len_ext;
      xneg_c = 1'b1;
    end else begin
      xmag   = len_ext - prod_p;
      xneg_c = 1'b0;
    end
  end

  // signed bar count, shared by queries, and snapping when a signature is applied
  assign q_signed = neg ? (TIME_W'(0) - div_rsp.quot[TIME_W-1:0]) : div_rsp.quot[TIME_W-1:0];
  assign rem_ext  = {{(TIME_W-LEN_W){1'b0}}, div_rsp.rem};
  assign snap     = !neg && (div_rsp.rem > {1'b0, bar_len[LEN_W-1:1]});
  assign last_bar = neg ? (e.tick + rem_ext) : (e.tick - rem_ext);

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    s_tready         = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    div_req.start    = 1'b0;
    div_req.divisor  = bar_len;
    div_req.dividend = {d_mag, 10'd0};
    div_req.steps    = STEPS_BARS;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (cmd == CMD_QUERY) begin
          state_next = S_FETCH;
        end else begin
          push       = (cmd == CMD_ENQUEUE) && !zero_len && !full;
          state_next = S_DONE;
        end
      end
      S_FETCH: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (can_apply) begin
          pop        = 1'b1;
          state_next = S_MUL1;
        end else begin
          state_next = S_QSTART;
        end
      end
      S_MUL1: begin
        state_next = S_MUL2;
      end
      S_MUL2: begin
        state_next = S_APSTART;
      end
      S_APSTART: begin
        if (new_len == '0) begin
          state_next = S_FETCH;
        end else begin
          div_req.start = 1'b1;
          state_next    = S_APWAIT;
        end
      end
      S_APWAIT: begin
        if (div_rsp.done) begin
          state_next = S_FETCH;
        end
      end
      S_QSTART: begin
        div_req.start = 1'b1;
        state_next    = S_QWAIT;
      end
      S_QWAIT: begin
        if (div_rsp.done) begin
          state_next = S_QMUL;
        end
      end
      S_QMUL: begin
        state_next = S_QSUM;
      end
      S_QSUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = {xmag, 8'd0};
        div_req.steps    = STEPS_BEAT;
        state_next       = S_BWAIT;
      end
      S_BWAIT: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control and timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      tpq       <= TPQ_RESET;
      base_tick <= '0;
      base_bar  <= '0;
      bar_len   <= DEFAULT_BAR_TICKS;
      beats     <= DEFAULT_BEATS;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        tpq <= cfg_wdata;
      end
      if ((state == S_DECODE) && (cmd == CMD_RESET)) begin
        base_tick <= '0;
        base_bar  <= '0;
        bar_len   <= DEFAULT_BAR_TICKS;
        beats     <= DEFAULT_BEATS;
      end
      if ((state == S_APWAIT) && div_rsp.done) begin
        base_tick <= last_bar + (snap ? {{(TIME_W-LEN_W){1'b0}}, bar_len} : TIME_W'(0));
        base_bar  <= base_bar + q_signed;
        bar_len   <= new_len;
        beats     <= e.num;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd    <= cmd_t'(s_tuser);
          tick   <= s_tdata[31:0];
          in_num <= s_tdata[39:32];
          in_den <= s_tdata[45:40];
        end
      end
      S_DECODE: begin
        res_bar  <= '0;
        res_beat <= '0;
        if ((cmd == CMD_ENQUEUE) && zero_len) begin
          res_status <= ST_ZERO_LEN;
        end else if ((cmd == CMD_ENQUEUE) && full) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_OK;
        end
      end
      S_CHECK: begin
        e <= head_entry;
      end
      S_MUL1: begin
        prod1 <= e.num * tpq[14:3];
      end
      S_MUL2: begin
        new_len <= {6'd0, prod1} * {20'd0, DEN_QUOT[e.den]};
      end
      S_APSTART: begin
        neg <= d_neg;
      end
      S_QSTART: begin
        neg <= d_neg;
      end
      S_QWAIT: begin
        if (div_rsp.done) begin
          bars32 <= q_signed;
          rmag   <= div_rsp.rem;
        end
      end
      S_QMUL: begin
        prod_p <= beats * rmag;
      end
      S_QSUM: begin
        xneg <= xneg_c;
      end
      S_BWAIT: begin
        if (div_rsp.done) begin
          res_status <= ST_OK;
          res_bar    <= base_bar + bars32 + TIME_W'(1);
          res_beat   <= xneg ? (18'd0 - div_rsp.quot[17:0]) : div_rsp.quot[17:0];
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status <= res_status;
      out_bar    <= res_bar;
      out_beat   <= res_beat;
    end
  end

  assign m_tdata = {6'd0, out_beat, out_bar};
  assign m_tuser = out_status;

endmodule

// ----- sv/mtbb_sig_fifo.sv -----
// time signature queue held in a synchronous memory with registered head read
`timescale 1ns / 1ps

module mtbb_sig_fifo import mtbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sig_entry_t        wr_entry,
  input  logic              pop,
  output sig_entry_t        head_entry,
  output logic [QCNT_W-1:0] count
);

  sig_entry_t mem [QUEUE_DEPTH];

  logic [QIDX_W-1:0] head;
  logic [QIDX_W-1:0] tail;

  function automatic logic [QIDX_W-1:0] wrap_inc(input logic [QIDX_W-1:0] idx);
    logic [QIDX_W-1:0] res;
    if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wr_entry;
    end
    head_entry <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= wrap_inc(tail);
      end
      if (pop) begin
        head <= wrap_inc(head);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/mtbb_div.sv -----
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module mtbb_div import mtbb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [LEN_W-1:0]  rem;
  logic [DIV_W-1:0]  dq;
  logic [LEN_W-1:0]  divisor;

  logic [LEN_W:0]    shifted;
  logic [LEN_W+1:0]  trial;
  logic              fits;

  assign shifted = {rem, dq[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = !trial[LEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      dq      <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
      dq  <= {dq[DIV_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dq;
  assign rsp.rem  = rem;

endmodule

// ----- dv/midi_tick_to_bar_beat_test.sv -----
// self-checking testbench for the tick to bar and beat converter, directed table then random
`timescale 1ns / 1ps

module midi_tick_to_bar_beat_test;
  import mtbb_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] bar;
    logic [17:0] beat;
  } bar_beat_t;

  typedef struct packed {
    logic        cfg_on;
    logic [14:0] cfg_val;
    cmd_t        cmd;
    logic [31:0] tick;
    logic [7:0]  num;
    logic [5:0]  den;
    logic [4:0]  reps;
    logic        known;
    bar_beat_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_QUERY;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = TPQ_RESET;

  midi_tick_to_bar_beat dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  sig_entry_t  sig_fifo [QUEUE_DEPTH];
  int unsigned fifo_head, fifo_tail, fifo_count;
  logic [31:0] base_tick, base_bar;
  int unsigned bar_len, beats, tpq;

  bar_beat_t   awaited [$];
  plan_row_t   plan [$];
  bit          quiet = 1'b0;
  int          errors = 0;
  int unsigned sent = 0, checked = 0, writes = 0, queries = 0;
  int unsigned stall_left = 0;

  function automatic int unsigned bar_len_of(int unsigned num, int unsigned den);
    if (den == 0 || den > 32) return 0;
    return num * (tpq / 8) * (32 / den);
  endfunction

  task automatic apply_signature(input sig_entry_t e);
    int unsigned len;
    longint tl, bl, lenl, bars, last_bar, rem, snapped;
    len = bar_len_of(e.num, e.den);
    if (len == 0) return;
    tl = e.tick;
    bl = base_tick;
    lenl = bar_len;
    bars = (tl - bl) / lenl;
    last_bar = bl + bars * lenl;
    rem = tl - last_bar;
    if (rem > longint'(bar_len / 2)) snapped = last_bar + lenl;
    else snapped = last_bar;
    base_tick = snapped[31:0];
    base_bar = base_bar + bars[31:0];
    bar_len = len;
    beats = e.num;
  endtask

  task automatic predict_bar_beat(input cmd_t cmd, input logic [31:0] tick,
                                  input logic [7:0] num, input logic [5:0] den,
                                  output bar_beat_t res);
    sig_entry_t e;
    longint tl, diff, lenl, bars, offset, scaled, beat;
    res = '0;
    case (cmd)
      CMD_QUERY: begin
        while (fifo_count > 0 && sig_fifo[fifo_head].tick <= tick) begin
          e = sig_fifo[fifo_head];
          fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
          fifo_count--;
          apply_signature(e);
        end
        tl = tick;
        diff = tl - longint'(base_tick);
        lenl = bar_len;
        bars = diff / lenl;
        offset = diff - bars * lenl;
        scaled = (lenl + longint'(beats) * offset) * 256;
        beat = scaled / lenl;
        res.bar = base_bar + bars[31:0] + 32'd1;
        res.beat = beat[17:0];
      end
      CMD_ENQUEUE: begin
        if (bar_len_of(num, den) == 0) begin
          res.status = ST_ZERO_LEN;
        end else if (fifo_count >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          sig_fifo[fifo_tail] = '{tick: tick, num: num, den: den};
          fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
          fifo_count++;
        end
      end
      CMD_RESET: begin
        base_tick = '0;
        base_bar = '0;
        bar_len = DEFAULT_BAR_TICKS;
        beats = DEFAULT_BEATS;
      end
      default: ;
    endcase
  endtask

  task automatic send_transfer(input cmd_t cmd, input logic [31:0] tick,
                               input logic [7:0] num, input logic [5:0] den,
                               input bit known, input bar_beat_t want);
    bar_beat_t res;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, den, num, tick};
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    predict_bar_beat(cmd, tick, num, den, res);
    awaited.push_back(known ? want : res);
    sent++;
    if (cmd == CMD_QUERY) queries++;
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tpq(input logic [14:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tpq = value;
    writes++;
  endtask

  task automatic add_row(input logic cfg_on, input logic [14:0] cfg_val, input cmd_t cmd,
                         input logic [31:0] tick, input logic [7:0] num,
                         input logic [5:0] den, input logic [4:0] reps, input logic known,
                         input status_t status, input logic [31:0] bar,
                         input logic [17:0] beat);
    plan_row_t r;
    r.cfg_on = cfg_on;
    r.cfg_val = cfg_val;
    r.cmd = cmd;
    r.tick = tick;
    r.num = num;
    r.den = den;
    r.reps = reps;
    r.known = known;
    r.want = '{status: status, bar: bar, beat: beat};
    plan.push_back(r);
  endtask

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(1, 10) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    bar_beat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{status: m_tuser, bar: m_tdata[31:0], beat: m_tdata[49:32]};
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result status=%0d bar=%0d beat=%h",
                   $realtime, got.status, got.bar, got.beat);
      end else begin
        want = awaited.pop_front();
        checked++;
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch status %0d/%0d bar %0d/%0d beat %h/%h (exp/act)",
                     $realtime, want.status, got.status, want.bar, got.bar,
                     want.beat, got.beat);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] cursor, tick;
    logic [7:0]  num;
    logic [5:0]  den;
    cmd_t        cmd;
    int unsigned n, r, len;
    plan_row_t   row;

    fifo_head = 0;
    fifo_tail = 0;
    fifo_count = 0;
    base_tick = '0;
    base_bar = '0;
    bar_len = DEFAULT_BAR_TICKS;
    beats = DEFAULT_BEATS;
    tpq = TPQ_RESET;

    add_row(0, 0, CMD_QUERY,   32'd0,          0,   0,  1, 1, ST_OK,       1, 256);
    add_row(0, 0, CMD_QUERY,   32'd480,        0,   0,  1, 1, ST_OK,       1, 768);
    add_row(0, 0, CMD_QUERY,   32'd960,        0,   0,  1, 1, ST_OK,       2, 256);
    add_row(0, 0, CMD_QUERY,   32'hFFFF_FFFF,  255, 63, 1, 0, ST_OK,       0, 0);
    add_row(0, 0, CMD_ENQUEUE, 32'd0,          4,   0,  1, 1, ST_ZERO_LEN, 0, 0);
    add_row(0, 0, CMD_ENQUEUE, 32'd0,          1,   33, 1, 1, ST_ZERO_LEN, 0, 0);
    add_row(0, 0, CMD_ENQUEUE, 32'hFFFF_FFFF,  255, 63, 1, 1, ST_ZERO_LEN, 0, 0);
    add_row(0, 0, CMD_NONE,    32'hFFFF_FFFF,  255, 63, 1, 1, ST_OK,       0, 0);
    // out of order pair: the later entry waits behind the head
    add_row(0, 0, CMD_ENQUEUE, 32'd1000,       3,   4,  1, 1, ST_OK,       0, 0);
    add_row(0, 0, CMD_ENQUEUE, 32'd500,        7,   8,  1, 1, ST_OK,       0, 0);
    add_row(0, 0, CMD_QUERY,   32'd900,        0,   0,  1, 0, ST_OK,       0, 0);
    add_row(0, 0, CMD_QUERY,   32'd2000,       0,   0,  1, 0, ST_OK,       0, 0);
    add_row(0, 0, CMD_RESET,   32'd0,          0,   0,  1, 1, ST_OK,       0, 0);
    // forward snap puts the base past the query, beat below one
    add_row(0, 0, CMD_ENQUEUE, 32'd700,        4,   4,  1, 1, ST_OK,       0, 0);
    add_row(0, 0, CMD_QUERY,   32'd800,        0,   0,  1, 0, ST_OK,       0, 0);
    add_row(1, 7, CMD_ENQUEUE, 32'd100,        4,   4,  1, 1, ST_ZERO_LEN, 0, 0);
    add_row(1, 32767, CMD_ENQUEUE, 32'd100,    255, 1,  1, 1, ST_OK,       0, 0);
    add_row(0, 0, CMD_QUERY,   32'd100,        0,   0,  1, 0, ST_OK,       0, 0);
    // division drops below eight while an entry is queued
    add_row(0, 0, CMD_ENQUEUE, 32'd5000,       2,   2,  1, 1, ST_OK,       0, 0);
    add_row(1, 3, CMD_QUERY,   32'd6000,       0,   0,  1, 0, ST_OK,       0, 0);
    add_row(1, 480, CMD_RESET, 32'd0,          0,   0,  1, 1, ST_OK,       0, 0);
    // fill the queue, base tick wraps on apply
    add_row(0, 0, CMD_ENQUEUE, 32'd10,         5,   16, 1, 1, ST_OK,       0, 0);
    add_row(0, 0, CMD_ENQUEUE, 32'hFFFF_FFFF,  5,   16, 15, 1, ST_OK,      0, 0);
    add_row(0, 0, CMD_ENQUEUE, 32'd0,          1,   1,  1, 1, ST_FULL,     0, 0);
    add_row(0, 0, CMD_QUERY,   32'hFFFF_FFFF,  0,   0,  1, 0, ST_OK,       0, 0);
    add_row(0, 0, CMD_RESET,   32'd0,          0,   0,  1, 1, ST_OK,       0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.cfg_on) write_tpq(row.cfg_val);
      repeat (row.reps)
        send_transfer(row.cmd, row.tick, row.num, row.den, row.known, row.want);
    end

    cursor = $urandom_range(0, 5000);
    while (sent < 600) begin
      case ($urandom_range(0, 9))
        0: write_tpq(15'd8);
        1: write_tpq(15'd32767);
        2: write_tpq(TPQ_RESET);
        3: write_tpq(15'($urandom_range(0, 7)));
        4: write_tpq(15'd960);
        default: write_tpq(15'($urandom_range(8, 32767)));
      endcase
      quiet = (sent >= 530) || ($urandom_range(0, 3) == 0);
      n = $urandom_range(30, 70);
      repeat (n) begin
        len = bar_len;
        r = $urandom_range(0, 99);
        num = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 16))
                                         : 8'($urandom_range(0, 255));
        den = ($urandom_range(0, 9) < 8) ? 6'(32'd1 << $urandom_range(0, 5))
                                         : 6'($urandom_range(0, 63));
        if (r < 45) begin
          cmd = CMD_QUERY;
          tick = cursor + $urandom_range(0, 3 * len) - $urandom_range(0, len);
          cursor = cursor + $urandom_range(0, len);
        end else if (r < 80) begin
          cmd = CMD_ENQUEUE;
          tick = cursor + $urandom_range(0, 2 * len);
          cursor = tick;
        end else if (r < 85) begin
          cmd = CMD_RESET;
          tick = $urandom;
          cursor = $urandom_range(0, 5000);
        end else if (r < 90) begin
          cmd = CMD_NONE;
          tick = $urandom;
        end else begin
          cmd = cmd_t'($urandom_range(0, 3));
          tick = $urandom;
          num = 8'($urandom);
          den = 6'($urandom);
        end
        send_transfer(cmd, tick, num, den, 1'b0, '0);
      end
    end

    settle();
    repeat (100) @(negedge clk);
    errors += awaited.size();
    $display("%0d transfers (%0d queries) sent, %0d results checked, %0d division writes",
             sent, queries, checked, writes);
    $display("%0d mismatches over directed table and random phases", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mtbb_pkg.sv
sv/mtbb_sig_fifo.sv
sv/mtbb_div.sv
sv/midi_tick_to_bar_beat.sv
dv/midi_tick_to_bar_beat_test.sv
